// File: hdl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  // operation codes on the input tuser field
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd4;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [4:0] SEQ_LEN_SHORT = 5'd3;
  localparam logic [4:0] SEQ_LEN_WRITE = 5'd28;
  localparam logic [4:0] SEQ_LEN_READ  = 5'd21;

  typedef enum logic [2:0] {
    K_TICK,
    K_START,
    K_STOP,
    K_WRITE,
    K_READ,
    K_NOP
  } cmd_kind_e;

  // classified item, as it sits in the queue
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        ack;
    logic        sda;
  } item_t;

  function automatic logic [4:0] seq_len(cmd_kind_e k);
    logic [4:0] len;
    unique case (k)
      K_WRITE: len = SEQ_LEN_WRITE;
      K_READ:  len = SEQ_LEN_READ;
      default: len = SEQ_LEN_SHORT;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hdl/i2cm_front.sv
`default_nettype none

module i2cm_front #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    in_op_i,
  input  wire logic [7:0]    in_data_i,
  input  wire logic          in_ack_i,
  input  wire logic          in_sda_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output i2cm_pkg::item_t    q_item_o
);
  import i2cm_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  item_t          mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  item_t          cls;
  logic           push, pop;

  // classify the operation code
  always_comb begin
    cls.data = in_data_i;
    cls.ack  = in_ack_i;
    cls.sda  = in_sda_i;
    unique case (in_op_i)
      OP_TICK:  cls.kind = K_TICK;
      OP_START: cls.kind = K_START;
      OP_STOP:  cls.kind = K_STOP;
      OP_WRITE: cls.kind = K_WRITE;
      OP_READ:  cls.kind = K_READ;
      default:  cls.kind = K_NOP;
    endcase
  end

  assign in_ready_o = (cnt_q != CW'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: hdl/i2cm_back.sv
`default_nettype none

module i2cm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  wire i2cm_pkg::item_t q_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [15:0]        out_data_o
);
  import i2cm_pkg::*;

  logic [15:0] ticks_q;
  logic        err_q, err_d;
  logic        busy_q, busy_d;
  cmd_kind_e   cmd_q, cmd_d;
  logic [4:0]  ph_q, ph_d;
  logic [1:0]  m3_q, m3_d;      // phase index mod 3, for the write bit slots
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  rbyte_q, rbyte_d;
  logic        ackc_q, ackc_d;
  logic        scl_q, scl_d;
  logic        sdad_q, sdad_d;
  logic        done, rej;
  logic        do_ph;
  logic [15:0] limit;
  logic [16:0] cnt_inc;
  logic [4:0]  ph_next;
  logic [1:0]  m3_next;
  logic        ovalid_q;
  logic [15:0] odata_q;
  logic        step;

  assign q_ready_o = !ovalid_q || out_ready_i;
  assign step      = q_valid_i && q_ready_o;
  assign limit     = (ticks_q == '0) ? 16'd1 : ticks_q;
  assign cnt_inc   = {1'b0, cnt_q} + 17'd1;
  assign ph_next   = ph_q + 5'd1;
  assign m3_next   = (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;

  always_comb begin
    err_d   = err_q;
    busy_d  = busy_q;
    cmd_d   = cmd_q;
    ph_d    = ph_q;
    m3_d    = m3_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rbyte_d = rbyte_q;
    ackc_d  = ackc_q;
    scl_d   = scl_q;
    sdad_d  = sdad_q;
    done    = 1'b0;
    rej     = 1'b0;
    do_ph   = 1'b0;

    unique case (q_item_i.kind)
      K_TICK: begin
        if (busy_q) begin
          if (cnt_inc >= {1'b0, limit}) begin
            cnt_d = '0;
            if (ph_next >= seq_len(cmd_q)) begin
              busy_d = 1'b0;
              ph_d   = '0;
              m3_d   = '0;
              done   = 1'b1;
              if (cmd_q == K_READ) begin
                rbyte_d = shift_q;
              end
              if (cmd_q == K_STOP) begin
                err_d  = 1'b0;
                scl_d  = 1'b0;
                sdad_d = 1'b0;
              end
            end else begin
              ph_d  = ph_next;
              m3_d  = m3_next;
              do_ph = 1'b1;
            end
          end else begin
            cnt_d = cnt_inc[15:0];
          end
        end
      end
      K_START, K_STOP, K_WRITE, K_READ: begin
        if (busy_q) begin
          rej = 1'b1;
        end else if (q_item_i.kind != K_STOP && err_q) begin
          done = 1'b1;
          if (q_item_i.kind == K_READ) begin
            rbyte_d = '0;
          end
        end else begin
          cmd_d  = q_item_i.kind;
          busy_d = 1'b1;
          ph_d   = '0;
          m3_d   = '0;
          cnt_d  = '0;
          if (q_item_i.kind == K_WRITE) begin
            shift_d = q_item_i.data;
          end
          if (q_item_i.kind == K_READ) begin
            shift_d = '0;
            ackc_d  = q_item_i.ack;
          end
          do_ph = 1'b1;
        end
      end
      default: ;
    endcase

    // bus phase action on the updated phase index
    if (do_ph) begin
      unique case (cmd_d)
        K_START: begin
          if (ph_d == 5'd0)      scl_d  = 1'b0;
          else if (ph_d == 5'd1) sdad_d = 1'b1;
          else                   scl_d  = 1'b1;
        end
        K_STOP: begin
          if (ph_d == 5'd0)      sdad_d = 1'b1;
          else if (ph_d == 5'd1) scl_d  = 1'b0;
          else                   sdad_d = 1'b0;
        end
        K_WRITE: begin
          if (ph_d < 5'd24) begin
            if (m3_d == 2'd0) begin
              sdad_d = ~shift_d[7];
            end else if (m3_d == 2'd1) begin
              scl_d = 1'b0;
            end else begin
              scl_d   = 1'b1;
              shift_d = {shift_d[6:0], 1'b0};
            end
          end else if (ph_d == 5'd24) begin
            sdad_d = 1'b0;
          end else if (ph_d == 5'd25) begin
            scl_d = 1'b0;
          end else if (ph_d == 5'd26) begin
            err_d = q_item_i.sda;
            scl_d = 1'b1;
          end else begin
            sdad_d = 1'b1;
          end
        end
        default: begin
          if (ph_d == 5'd0) begin
            sdad_d = 1'b0;
          end else if (ph_d <= 5'd16) begin
            if (ph_d[0]) begin
              scl_d = 1'b0;
            end else begin
              shift_d = {shift_d[6:0], q_item_i.sda};
              scl_d   = 1'b1;
            end
          end else if (ph_d == 5'd17) begin
            sdad_d = 1'b1;
          end else if (ph_d == 5'd18) begin
            sdad_d = ackc_d;
          end else if (ph_d == 5'd19) begin
            scl_d = 1'b0;
          end else begin
            scl_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q  <= PHASE_TICKS_RST;
      err_q    <= 1'b0;
      busy_q   <= 1'b0;
      cmd_q    <= K_TICK;
      ph_q     <= '0;
      m3_q     <= '0;
      cnt_q    <= '0;
      shift_q  <= '0;
      rbyte_q  <= '0;
      ackc_q   <= 1'b0;
      scl_q    <= 1'b0;
      sdad_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      if (step) begin
        err_q   <= err_d;
        busy_q  <= busy_d;
        cmd_q   <= cmd_d;
        ph_q    <= ph_d;
        m3_q    <= m3_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        rbyte_q <= rbyte_d;
        ackc_q  <= ackc_d;
        scl_q   <= scl_d;
        sdad_q  <= sdad_d;
      end
      if (step) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      odata_q <= {2'b00, rej, err_d, rbyte_d, done, busy_d, sdad_d, scl_d};
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

`default_nettype wire

// File: hdl/i2c_master_byte_engine.sv
// I2C master byte engine: one result per accepted item, in order.
// Each item passes through its queue entry, then the result register; the back end takes
// an item only while its result slot is free or the held result is being taken.
// Throughput: one item per cycle while results are taken, each applied to back-end state.
// Ticks per bus phase come from phase_ticks; a write spans 28 phases, a read 21.
// Reset (rst_ni low, async): queue empty, both lines released, no error, phase_ticks = 4.
`default_nettype none

module i2c_master_byte_engine #(
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // phase_ticks register
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] data_byte, [8] send_ack, [9] sda_level
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] operation
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [0] scl_low, [1] sda_low, [2] busy_res,
                                          // [3] done_res, [11:4] read_data,
                                          // [12] ack_error, [13] rejected
);
  import i2cm_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // front end: classify and buffer, so the input keeps flowing, until the queue is full,
  // while a result waits on the output side
  i2cm_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_data_i  (s_axis_tdata[7:0]),
    .in_ack_i   (s_axis_tdata[8]),
    .in_sda_i   (s_axis_tdata[9]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  // back end: phase sequencer, tick counter, line drivers, result register
  i2cm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // a finished or skipped command never leaves the engine busy
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done with busy set");

  // a rejected command only happens while a sequence runs
  a_rej_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[2] && !m_axis_tdata[3])
    else $error("reject outside busy");

  // queue drains into the back end whenever the result slot is free
  a_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("back end stalled with free slot");

endmodule

`default_nettype wire
